@@ hdl/fscc_pkg.sv @@
// shared types and constants of the flash save command controller
`default_nettype none

package fscc_pkg;

	localparam int FUNC_W   = 2;
	localparam int WORD_W   = 32;
	localparam int OFFSET_W = 17;
	localparam int HW_W     = 16;
	localparam int OPC_W    = 8;
	localparam int STAT_W   = 4;

	typedef enum logic [1:0] {
		FUNC_CMD   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		MODE_READ     = 2'd0,
		MODE_STATUS   = 2'd1,
		MODE_IDENTIFY = 2'd2,
		MODE_PROGRAM  = 2'd3
	} mode_t;

	localparam logic [OPC_W-1:0] OP_STATUS       = 8'hD2;
	localparam logic [OPC_W-1:0] OP_IDENTIFY     = 8'hE1;
	localparam logic [OPC_W-1:0] OP_READ         = 8'hF0;
	localparam logic [OPC_W-1:0] OP_ARM_ERASE    = 8'h4B;
	localparam logic [OPC_W-1:0] OP_DO_ERASE     = 8'h78;
	localparam logic [OPC_W-1:0] OP_PROGRAM_MODE = 8'hB4;
	localparam logic [OPC_W-1:0] OP_DO_PROGRAM   = 8'hA5;

	localparam logic [STAT_W-1:0] ST_PROGRAM_OK = 4'h4;
	localparam logic [STAT_W-1:0] ST_ERASE_OK   = 4'h8;

	localparam logic [WORD_W-1:0] SILICON_ID = 32'h1111_8001;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_RDWAIT = 5'b00100,
		S_ERASE  = 5'b01000,
		S_PROG   = 5'b10000
	} state_t;

endpackage

`default_nettype wire

@@ hdl/flash_save_command_controller_unit.sv @@
// flash save command controller: command decode, page buffer and array memory
`default_nettype none

// Device side of a NOR flash save chip; one input beat is one bus access and gives one
// result beat. After reset the array is swept to ones, one halfword a cycle, and no
// access is taken meanwhile (the register write is). Command writes, buffer writes,
// identify and status reads load the output register directly; an array read first
// passes the registered read of the array memory. Execute-erase then stalls the port
// while it writes each halfword of the sector (clipped to the array), execute-program
// while it copies the page buffer into its page; both are bound by the single array
// write port. All three sizes must be powers of two; the block does not check this.
module flash_save_command_controller_unit #(
	parameter int ARRAY_BYTES  = 131072,
	parameter int SECTOR_BYTES = 16384,
	parameter int PAGE_BYTES   = 128
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fscc_pkg::WORD_W-1:0]       cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [fscc_pkg::FUNC_W-1:0]       func,
	input  wire logic [fscc_pkg::WORD_W-1:0]       word,
	input  wire logic [fscc_pkg::OFFSET_W-1:0]     offset,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [fscc_pkg::WORD_W-1:0]            read_data,
	output logic [1:0]                             mode_now
);

	localparam int ARRAY_HW  = ARRAY_BYTES / 2;
	localparam int PAGE_HW   = PAGE_BYTES / 2;
	localparam int AW        = $clog2(ARRAY_HW);
	localparam int PW        = $clog2(PAGE_HW);
	localparam int NUM_PAGES = (ARRAY_BYTES / PAGE_BYTES) > 0 ? (ARRAY_BYTES / PAGE_BYTES) : 1;
	localparam int PGW       = NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1;
	localparam int PPS       = (SECTOR_BYTES / PAGE_BYTES) > 0 ? (SECTOR_BYTES / PAGE_BYTES) : 1;
	localparam int PPS_EFF   = PPS < NUM_PAGES ? PPS : NUM_PAGES;
	localparam int ERASE_HW  = PPS_EFF * PAGE_HW;

	localparam logic [PGW-1:0] PAGE_MASK   = PGW'(NUM_PAGES - 1);
	localparam logic [PGW-1:0] SECTOR_MASK = PGW'(PPS_EFF - 1);
	localparam logic [AW-1:0]  LAST_CLEAR  = AW'(ARRAY_HW - 1);
	localparam logic [AW-1:0]  LAST_ERASE  = AW'(ERASE_HW - 1);
	localparam logic [AW-1:0]  LAST_PROG   = AW'(PAGE_HW - 1);
	localparam logic [fscc_pkg::HW_W-1:0] ERASED = '1;

	// memories
	logic [fscc_pkg::HW_W-1:0] arr_mem [ARRAY_HW];
	logic [fscc_pkg::HW_W-1:0] pbuf_mem [PAGE_HW];

	fscc_pkg::state_t state_q;
	fscc_pkg::mode_t  mode_q;
	logic [PGW-1:0]               armed_q;
	logic [fscc_pkg::STAT_W-1:0]  status_q;
	logic [fscc_pkg::WORD_W-1:0]  id_q;
	logic [AW-1:0]                base_q;
	logic [AW-1:0]                walk_q;
	logic [PAGE_HW-1:0]           pbuf_vld_q;

	logic                         out_valid_q;
	logic [fscc_pkg::WORD_W-1:0]  out_data_q;
	fscc_pkg::mode_t              out_mode_q;

	logic [fscc_pkg::HW_W-1:0]    arr_rdata_q;
	logic                         prog_wr_s1;
	logic [AW-1:0]                prog_addr_s1;
	logic [fscc_pkg::HW_W-1:0]    pbuf_rd_s1;
	logic                         pbuf_rdv_s1;

	logic                         out_free;
	logic                         out_set;
	logic                         acc;
	logic [PGW-1:0]               cmd_page;
	logic [fscc_pkg::WORD_W-1:0]  id_word;
	logic [fscc_pkg::HW_W-1:0]    id_half;
	logic                         arr_rd;
	logic [AW-1:0]                arr_raddr;
	logic                         arr_we;
	logic [AW-1:0]                arr_waddr;
	logic [fscc_pkg::HW_W-1:0]    arr_wdata;
	logic                         pbuf_we;
	logic [PW-1:0]                pbuf_waddr;
	logic                         walk_last;

	// next-state decode of an accepted beat
	fscc_pkg::mode_t              nx_mode;
	logic [PGW-1:0]               nx_armed;
	logic [fscc_pkg::STAT_W-1:0]  nx_status;
	fscc_pkg::state_t             nx_state;
	logic [AW-1:0]                nx_base;
	logic [fscc_pkg::WORD_W-1:0]  nx_rd;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == fscc_pkg::S_IDLE) && out_free && !prog_wr_s1);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign read_data = out_data_q;
	assign mode_now  = out_mode_q;

	// array reads deliver their beat once the memory answers
	assign out_set   = (acc && (nx_state != fscc_pkg::S_RDWAIT))
		|| (state_q == fscc_pkg::S_RDWAIT);

	assign cmd_page  = PGW'(word[23:0]) & PAGE_MASK;
	assign id_word   = offset[2] ? id_q : fscc_pkg::SILICON_ID;
	assign id_half   = offset[1] ? id_word[15:0] : id_word[31:16];
	assign arr_raddr = AW'(offset[fscc_pkg::OFFSET_W-1:1]);
	assign arr_rd    = acc && (func == fscc_pkg::FUNC_READ) && (mode_q == fscc_pkg::MODE_READ);

	assign pbuf_waddr = PW'(offset[fscc_pkg::OFFSET_W-1:1]);
	assign pbuf_we    = acc && (func == fscc_pkg::FUNC_WRITE)
		&& (mode_q == fscc_pkg::MODE_PROGRAM);

	always_comb begin
		case (state_q)
			fscc_pkg::S_CLEAR: walk_last = (walk_q == LAST_CLEAR);
			fscc_pkg::S_ERASE: walk_last = (walk_q == LAST_ERASE);
			fscc_pkg::S_PROG:  walk_last = (walk_q == LAST_PROG);
			default:           walk_last = 1'b0;
		endcase
	end

	// sweeps write ones; the program copy writes one stage behind the buffer read
	always_comb begin
		arr_we    = 1'b0;
		arr_waddr = base_q | walk_q;
		arr_wdata = ERASED;
		if (prog_wr_s1) begin
			arr_we    = 1'b1;
			arr_waddr = prog_addr_s1;
			arr_wdata = pbuf_rdv_s1 ? pbuf_rd_s1 : ERASED;
		end else if (state_q == fscc_pkg::S_CLEAR || state_q == fscc_pkg::S_ERASE) begin
			arr_we = 1'b1;
		end
	end

	always_comb begin
		nx_mode   = mode_q;
		nx_armed  = armed_q;
		nx_status = status_q;
		nx_state  = fscc_pkg::S_IDLE;
		nx_base   = base_q;
		nx_rd     = '0;
		case (func)
			fscc_pkg::FUNC_CMD: begin
				case (word[31:24])
					fscc_pkg::OP_STATUS:       nx_mode = fscc_pkg::MODE_STATUS;
					fscc_pkg::OP_IDENTIFY:     nx_mode = fscc_pkg::MODE_IDENTIFY;
					fscc_pkg::OP_READ:         nx_mode = fscc_pkg::MODE_READ;
					fscc_pkg::OP_PROGRAM_MODE: nx_mode = fscc_pkg::MODE_PROGRAM;
					fscc_pkg::OP_ARM_ERASE:    nx_armed = cmd_page;
					fscc_pkg::OP_DO_ERASE: begin
						nx_mode   = fscc_pkg::MODE_STATUS;
						nx_status = fscc_pkg::ST_ERASE_OK;
						nx_state  = fscc_pkg::S_ERASE;
						nx_base   = AW'(armed_q & ~SECTOR_MASK) << PW;
					end
					fscc_pkg::OP_DO_PROGRAM: begin
						nx_mode   = fscc_pkg::MODE_STATUS;
						nx_status = fscc_pkg::ST_PROGRAM_OK;
						nx_state  = fscc_pkg::S_PROG;
						nx_base   = AW'(cmd_page) << PW;
					end
					default: ;
				endcase
			end
			fscc_pkg::FUNC_READ: begin
				case (mode_q)
					fscc_pkg::MODE_READ:     nx_state = fscc_pkg::S_RDWAIT;
					fscc_pkg::MODE_IDENTIFY: nx_rd = fscc_pkg::WORD_W'(id_half);
					default:                 nx_rd = fscc_pkg::WORD_W'(status_q);
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fscc_pkg::S_CLEAR;
			mode_q      <= fscc_pkg::MODE_READ;
			armed_q     <= '0;
			status_q    <= '0;
			id_q        <= '0;
			base_q      <= '0;
			walk_q      <= '0;
			pbuf_vld_q  <= '0;
			out_valid_q <= 1'b0;
			prog_wr_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				id_q <= cfg_wdata;
			end
			if (pbuf_we) begin
				pbuf_vld_q[pbuf_waddr] <= 1'b1;
			end
			prog_wr_s1 <= (state_q == fscc_pkg::S_PROG);

			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				fscc_pkg::S_IDLE: begin
					if (acc) begin
						mode_q   <= nx_mode;
						armed_q  <= nx_armed;
						status_q <= nx_status;
						state_q  <= nx_state;
						base_q   <= nx_base;
						walk_q   <= '0;
					end
				end
				fscc_pkg::S_RDWAIT: begin
					state_q <= fscc_pkg::S_IDLE;
				end
				fscc_pkg::S_CLEAR, fscc_pkg::S_ERASE, fscc_pkg::S_PROG: begin
					if (walk_last) begin
						walk_q  <= '0;
						state_q <= fscc_pkg::S_IDLE;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				default: state_q <= fscc_pkg::S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_data_q <= nx_rd;
			out_mode_q <= nx_mode;
		end else if (state_q == fscc_pkg::S_RDWAIT) begin
			out_data_q <= fscc_pkg::WORD_W'(arr_rdata_q);
		end
	end

	// program copy pipeline
	always_ff @(posedge clk) begin
		prog_addr_s1 <= base_q | walk_q;
		pbuf_rdv_s1  <= pbuf_vld_q[walk_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pbuf_we) begin
			pbuf_mem[pbuf_waddr] <= word[fscc_pkg::HW_W-1:0];
		end
		pbuf_rd_s1 <= pbuf_mem[walk_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (arr_we) begin
			arr_mem[arr_waddr] <= arr_wdata;
		end
		if (arr_rd) begin
			arr_rdata_q <= arr_mem[arr_raddr];
		end
	end

endmodule

`default_nettype wire
